FILE: rtl/ssfd_pkg.sv
// ----------------------------------------------------------------------------
// ssfd_pkg
// Shared types and constants for the stuffed sensor frame deframer.
// ----------------------------------------------------------------------------
package ssfd_pkg;

  // Configuration register indexes and reset values
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_FLAG_BYTE   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE_BYTE = 1'b1;
  localparam logic [7:0] FLAG_RESET   = 8'h7E;
  localparam logic [7:0] ESCAPE_RESET = 8'h7D;

  // Unstuffing mask applied to the byte after an escape
  localparam logic [7:0] STUFF_XOR = 8'h20;

  // Index of the closing flag within a frame
  localparam logic [3:0] LAST_INDEX = 4'd8;
  localparam int unsigned NumPayload = 7;

  // Receive mode codes as reported on the output
  localparam logic [1:0] RX_MODE_IDLE = 2'd0;
  localparam logic [1:0] RX_MODE_RECV = 2'd1;
  localparam logic [1:0] RX_MODE_ESC  = 2'd2;

  // Stream payload width: 74 bits of fields padded to whole bytes
  localparam int unsigned OutDataW = 80;

  // Receiver state, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_RECV = 3'b010,
    MODE_ESC  = 3'b100
  } mode_e;

  // One result item
  typedef struct packed {
    logic        frame_done;
    logic [7:0]  cell_count;
    logic [7:0]  sensor_id;
    logic [15:0] data_value;
    logic [7:0]  reserved_byte;
    logic [15:0] received_crc;
    logic [15:0] frame_total;
    logic [1:0]  rx_mode;
  } result_t;

endpackage

FILE: rtl/ssfd_core.sv
// ----------------------------------------------------------------------------
// ssfd_core
// Per-byte framing state machine: unstuffs, stores payload, counts frames
// and forms the result item for the byte being transferred.
// ----------------------------------------------------------------------------
module ssfd_core import ssfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] flag_byte_i,
  input  logic [7:0] escape_byte_i,
  output result_t    result_o
);

  mode_e       mode_q, mode_d;
  logic [3:0]  index_q, index_d;
  logic [15:0] total_q, total_d;
  logic [7:0]  payload_q [NumPayload];
  logic        store;
  logic [7:0]  store_byte;
  logic        done;
  logic        is_recv, is_esc, is_idle;

  assign is_recv = (mode_q == MODE_RECV);
  assign is_esc  = (mode_q == MODE_ESC);
  assign is_idle = !is_recv && !is_esc;

  // Next state for one byte
  always_comb begin
    mode_d     = mode_q;
    index_d    = index_q;
    total_d    = total_q;
    store      = 1'b0;
    store_byte = rx_byte_i;
    done       = 1'b0;
    if (rx_byte_i == flag_byte_i) begin
      if (is_idle) begin
        mode_d  = MODE_RECV;
        index_d = 4'd1;
      end else if (is_recv && index_q == LAST_INDEX) begin
        done    = 1'b1;
        total_d = total_q + 16'd1;
        mode_d  = MODE_IDLE;
        index_d = 4'd0;
      end else begin
        mode_d  = MODE_IDLE;
        index_d = 4'd0;
      end
    end else if (rx_byte_i == escape_byte_i) begin
      if (is_recv) begin
        mode_d = MODE_ESC;
      end else begin
        mode_d  = MODE_IDLE;
        index_d = 4'd0;
      end
    end else if (index_q < LAST_INDEX && is_recv) begin
      store   = 1'b1;
      index_d = index_q + 4'd1;
    end else if (index_q < LAST_INDEX && is_esc) begin
      store      = 1'b1;
      store_byte = rx_byte_i ^ STUFF_XOR;
      index_d    = index_q + 4'd1;
      mode_d     = MODE_RECV;
    end else begin
      mode_d  = MODE_IDLE;
      index_d = 4'd0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      index_q <= 4'd0;
      total_q <= 16'd0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      index_q <= index_d;
      total_q <= total_d;
    end
  end

  // Payload store, slot index-1 for indexes one through seven
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumPayload; i++) begin
      if (accept_i && store && index_q == 4'(i + 1)) begin
        payload_q[i] <= store_byte;
      end
    end
  end

  // Form the result; payload fields only on a completed frame
  always_comb begin
    result_o = '0;
    result_o.frame_done  = done;
    result_o.frame_total = total_d;
    case (mode_d)
      MODE_RECV: result_o.rx_mode = RX_MODE_RECV;
      MODE_ESC:  result_o.rx_mode = RX_MODE_ESC;
      default:   result_o.rx_mode = RX_MODE_IDLE;
    endcase
    if (done) begin
      result_o.cell_count    = payload_q[0];
      result_o.sensor_id     = payload_q[1];
      result_o.data_value    = {payload_q[3], payload_q[2]};
      result_o.reserved_byte = payload_q[4];
      result_o.received_crc  = {payload_q[6], payload_q[5]};
    end
  end

endmodule

FILE: rtl/stuffed_sensor_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// stuffed_sensor_frame_deframer_unit
// Byte-stuffed sensor frame receiver with a stream input and result output.
// ----------------------------------------------------------------------------
// Output: a byte's result is registered in the output register, or in the skid
// register while that waits. Throughput: one byte per cycle unless the skid is
// full; the two-entry buffer keeps input ready while one result waits downstream.
// Reset: mode goes idle, byte index and frame counter clear, flag and escape
// registers return to 0x7E and 0x7D; payload storage is not cleared.
module stuffed_sensor_frame_deframer_unit import ssfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic                m_axis_tlast,   // frame_done
  output logic [OutDataW-1:0] m_axis_tdata    // cell_count, sensor_id, data_value,
                                              // reserved_byte, received_crc,
                                              // frame_total, rx_mode, zero pad
);

  logic [7:0] flag_q, escape_q;
  logic       accept;
  logic       pop;
  result_t    result;
  result_t    out_q, skid_q;
  logic       out_valid_q, skid_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q   <= FLAG_RESET;
      escape_q <= ESCAPE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FLAG_BYTE:   flag_q   <= cfg_data_i;
        CFG_ESCAPE_BYTE: escape_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid_q && m_axis_tready;

  ssfd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (s_axis_tdata),
    .flag_byte_i   (flag_q),
    .escape_byte_i (escape_q),
    .result_o      (result)
  );

  // Output buffer valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (accept) begin
        if (out_valid_q && !pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output buffer payload: refill from skid first, else take the new result
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_valid_q && !pop) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.frame_done;
  assign m_axis_tdata  = {6'd0, out_q.rx_mode, out_q.frame_total, out_q.received_crc,
                          out_q.reserved_byte, out_q.data_value, out_q.sensor_id,
                          out_q.cell_count};

endmodule
